// ----- rtl/rmt_pkg.sv -----
package rmt_pkg;

    localparam int PASSES    = 5;
    localparam int RB        = 16;              // reading width, Q2.14
    localparam int FRAC      = RB - 2;
    localparam int WB        = 17;              // weight width, Q1.16
    localparam int SHARP_W   = 8;
    localparam int SHARP_RST = 20;
    localparam int DIV_STEPS = WB;              // quotient bits per division
    localparam int PROD_W    = WB + RB;         // w*x
    localparam int NUM_W     = PROD_W + 1;      // sum of three products
    localparam int DEN_W     = WB + 1;          // sum of three weights
    localparam int SQ_W      = 2 * RB;          // d*d
    localparam int SP_W      = SQ_W + SHARP_W;  // S*d*d
    localparam int REM_W     = SP_W + 1;        // divider remainder and divisor

    localparam logic [WB-1:0]    WEIGHT_ONE = WB'(1) << (WB - 1);
    localparam logic [REM_W-1:0] WDEN_ONE   = REM_W'(1) << (2 * FRAC);
    // 2^(16+2F) split into the part above the quotient bits and the rest (zero)
    localparam logic [REM_W-1:0] WNUM_HIGH  = REM_W'(1) << (WB - 1 + 2 * FRAC - DIV_STEPS);

    typedef logic [2:0][RB-1:0] rmt_trio_t;
    typedef logic [2:0][WB-1:0] rmt_wtrio_t;

endpackage

// ----- rtl/robust_mean_of_three_sensors.sv -----
// Robust mean of three sensor readings (iteratively reweighted mean).
// Input: pulse start with reading_a/b/c (unsigned Q2.14). busy is always low,
// so an item is taken in every cycle that start is high.
// Output: done is high for one cycle with robust_mean (unsigned Q2.14).
// Results come out in input order and cannot be held off by the receiver.
// Each pass registers products and sums, runs the mean division, registers the
// squared residual and divisor, then runs the weight divisions; five passes are
// chained. Throughput: one item per cycle, set by the chain of one-bit division
// cells that each item walks through.
// Config: cfg_write with cfg_data loads the sharpness factor S; write it only
// while no item is in flight. Reset sets S to 20 and empties the pipeline.
module robust_mean_of_three_sensors
    import rmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [RB-1:0]      reading_a,
    input  logic [RB-1:0]      reading_b,
    input  logic [RB-1:0]      reading_c,
    input  logic               cfg_write,
    input  logic [SHARP_W-1:0] cfg_data,
    output logic               done,
    output logic [RB-1:0]      robust_mean
);

    logic [SHARP_W-1:0] sharp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sharp_reg <= SHARP_W'(SHARP_RST);
        else if (cfg_write)
            sharp_reg <= cfg_data;
    end

    logic       p_v    [0:PASSES];
    rmt_trio_t  p_x    [0:PASSES];
    rmt_wtrio_t p_w    [0:PASSES];
    logic [RB-1:0] p_mean [1:PASSES];

    assign busy   = 1'b0;
    assign p_v[0] = start;
    assign p_x[0] = {reading_c, reading_b, reading_a};
    assign p_w[0] = {WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE};

    for (genvar p = 0; p < PASSES; p++)
    begin : g_pass
        rmt_pass u_pass (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (p_v[p]),
            .x_in      (p_x[p]),
            .w_in      (p_w[p]),
            .sharpness (sharp_reg),
            .valid_out (p_v[p+1]),
            .x_out     (p_x[p+1]),
            .w_out     (p_w[p+1]),
            .mean_out  (p_mean[p+1])
        );
    end

    assign done        = p_v[PASSES];
    assign robust_mean = p_mean[PASSES];

endmodule

// ----- rtl/rmt_div_cell.sv -----
module rmt_div_cell
    import rmt_pkg::*;
(
    input  logic                 clk,
    input  logic [REM_W-1:0]     rem_in,
    input  logic [DIV_STEPS-1:0] low_in,
    input  logic [REM_W-1:0]     div_in,
    output logic [REM_W-1:0]     rem_out,
    output logic [DIV_STEPS-1:0] low_out,
    output logic [REM_W-1:0]     div_out
);

    logic [REM_W:0]       trial;
    logic [REM_W:0]       diff;
    logic                 ge;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] low_reg;
    logic [REM_W-1:0]     div_reg;

    // one restoring step: quotient bit shifts into the vacated low end
    assign trial = {rem_in, low_in[DIV_STEPS-1]};
    assign diff  = trial - {1'b0, div_in};
    assign ge    = (trial >= {1'b0, div_in});

    always_ff @(posedge clk)
    begin
        rem_reg <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        low_reg <= {low_in[DIV_STEPS-2:0], ge};
        div_reg <= div_in;
    end

    assign rem_out = rem_reg;
    assign low_out = low_reg;
    assign div_out = div_reg;

endmodule

// ----- rtl/rmt_pass.sv -----
module rmt_pass
    import rmt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid_in,
    input  rmt_trio_t          x_in,
    input  rmt_wtrio_t         w_in,
    input  logic [SHARP_W-1:0] sharpness,
    output logic               valid_out,
    output rmt_trio_t          x_out,
    output rmt_wtrio_t         w_out,
    output logic [RB-1:0]      mean_out
);

    // stage 1: products and weight sum
    logic [PROD_W-1:0] prod1_reg [0:2];
    logic [DEN_W-1:0]  den1_reg;
    rmt_trio_t         x1_reg;
    logic              v1_reg;
    // stage 2: numerator
    logic [NUM_W-1:0]  num2_reg;
    logic [DEN_W-1:0]  den2_reg;
    rmt_trio_t         x2_reg;
    logic              v2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
            prod1_reg[k] <= PROD_W'(w_in[k]) * PROD_W'(x_in[k]);
        den1_reg <= DEN_W'(w_in[0]) + DEN_W'(w_in[1]) + DEN_W'(w_in[2]);
        x1_reg   <= x_in;
        num2_reg <= NUM_W'(prod1_reg[0]) + NUM_W'(prod1_reg[1]) + NUM_W'(prod1_reg[2]);
        den2_reg <= den1_reg;
        x2_reg   <= x1_reg;
    end

    // mean division chain
    logic [REM_W-1:0]     m_rem [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] m_low [0:DIV_STEPS];
    logic [REM_W-1:0]     m_div [0:DIV_STEPS];
    rmt_trio_t            m_x_reg [1:DIV_STEPS];
    logic                 m_v_reg [1:DIV_STEPS];

    assign m_rem[0] = REM_W'(num2_reg[NUM_W-1:DIV_STEPS]);
    assign m_low[0] = num2_reg[DIV_STEPS-1:0];
    assign m_div[0] = REM_W'(den2_reg);

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_mean
        rmt_div_cell u_cell (
            .clk     (clk),
            .rem_in  (m_rem[i]),
            .low_in  (m_low[i]),
            .div_in  (m_div[i]),
            .rem_out (m_rem[i+1]),
            .low_out (m_low[i+1]),
            .div_out (m_div[i+1])
        );
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    m_v_reg[1] <= 1'b0;
                else
                    m_v_reg[1] <= v2_reg;
            end
            always_ff @(posedge clk)
            begin
                m_x_reg[1] <= x2_reg;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    m_v_reg[i+1] <= 1'b0;
                else
                    m_v_reg[i+1] <= m_v_reg[i];
            end
            always_ff @(posedge clk)
            begin
                m_x_reg[i+1] <= m_x_reg[i];
            end
        end
    end

    logic [RB-1:0] mean;
    logic [RB-1:0] resid [0:2];

    assign mean = m_low[DIV_STEPS][RB-1:0];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            resid[k] = (mean >= m_x_reg[DIV_STEPS][k]) ? mean - m_x_reg[DIV_STEPS][k]
                                                        : m_x_reg[DIV_STEPS][k] - mean;
    end

    // stage 3: squared residual, stage 4: weight divisor
    logic [SQ_W-1:0]  dd3_reg [0:2];
    logic [RB-1:0]    mean3_reg;
    rmt_trio_t        x3_reg;
    logic             v3_reg;
    logic [REM_W-1:0] wden4_reg [0:2];
    logic [RB-1:0]    mean4_reg;
    rmt_trio_t        x4_reg;
    logic             v4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= m_v_reg[DIV_STEPS];
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            dd3_reg[k]   <= SQ_W'(resid[k]) * SQ_W'(resid[k]);
            wden4_reg[k] <= WDEN_ONE + REM_W'(SP_W'(sharpness) * SP_W'(dd3_reg[k]));
        end
        mean3_reg <= mean;
        x3_reg    <= m_x_reg[DIV_STEPS];
        mean4_reg <= mean3_reg;
        x4_reg    <= x3_reg;
    end

    // three weight division chains side by side
    logic [REM_W-1:0]     w_rem [0:2][0:DIV_STEPS];
    logic [DIV_STEPS-1:0] w_low [0:2][0:DIV_STEPS];
    logic [REM_W-1:0]     w_div [0:2][0:DIV_STEPS];
    rmt_trio_t            w_x_reg    [1:DIV_STEPS];
    logic [RB-1:0]        w_mean_reg [1:DIV_STEPS];
    logic                 w_v_reg    [1:DIV_STEPS];

    for (genvar k = 0; k < 3; k++)
    begin : g_lane
        assign w_rem[k][0] = WNUM_HIGH;
        assign w_low[k][0] = '0;
        assign w_div[k][0] = wden4_reg[k];
        for (genvar i = 0; i < DIV_STEPS; i++)
        begin : g_step
            rmt_div_cell u_cell (
                .clk     (clk),
                .rem_in  (w_rem[k][i]),
                .low_in  (w_low[k][i]),
                .div_in  (w_div[k][i]),
                .rem_out (w_rem[k][i+1]),
                .low_out (w_low[k][i+1]),
                .div_out (w_div[k][i+1])
            );
        end
        assign w_out[k] = w_low[k][DIV_STEPS][WB-1:0];
    end

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_wpay
        if (i == 0)
        begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    w_v_reg[1] <= 1'b0;
                else
                    w_v_reg[1] <= v4_reg;
            end
            always_ff @(posedge clk)
            begin
                w_x_reg[1]    <= x4_reg;
                w_mean_reg[1] <= mean4_reg;
            end
        end
        else
        begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    w_v_reg[i+1] <= 1'b0;
                else
                    w_v_reg[i+1] <= w_v_reg[i];
            end
            always_ff @(posedge clk)
            begin
                w_x_reg[i+1]    <= w_x_reg[i];
                w_mean_reg[i+1] <= w_mean_reg[i];
            end
        end
    end

    assign valid_out = w_v_reg[DIV_STEPS];
    assign x_out     = w_x_reg[DIV_STEPS];
    assign mean_out  = w_mean_reg[DIV_STEPS];

endmodule

// ----- tb/robust_mean_of_three_sensors_test.sv -----
module robust_mean_of_three_sensors_test;
    import rmt_pkg::*;

    typedef struct packed {
        logic [RB-1:0] a;
        logic [RB-1:0] b;
        logic [RB-1:0] c;
    } trio_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [RB-1:0]      reading_a = '0;
    logic [RB-1:0]      reading_b = '0;
    logic [RB-1:0]      reading_c = '0;
    logic               cfg_write = 1'b0;
    logic [SHARP_W-1:0] cfg_data = '0;
    logic               done;
    logic [RB-1:0]      robust_mean;

    trio_t         pending_items[$];
    logic [RB-1:0] expected_means[$];
    logic [7:0]    sharpness = 8'(SHARP_RST);
    int            idle_pct = 0;
    int            mismatches = 0;
    int            results_seen = 0;
    int            items_sent = 0;
    int            sharp_settings = 0;

    robust_mean_of_three_sensors dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .reading_a(reading_a), .reading_b(reading_b), .reading_c(reading_c),
        .cfg_write(cfg_write), .cfg_data(cfg_data),
        .done(done), .robust_mean(robust_mean)
    );

    always #2 clk = ~clk;

    function automatic logic [RB-1:0] reweighted_mean(trio_t t, logic [7:0] s);
        logic [63:0] x[3];
        logic [63:0] w[3];
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] mean;
        logic [63:0] d;
        mean = 0;
        x[0] = t.a;
        x[1] = t.b;
        x[2] = t.c;
        for (int k = 0; k < 3; k++)
            w[k] = 64'd1 << 16;
        for (int p = 0; p < PASSES; p++)
        begin
            num = 0;
            den = 0;
            for (int k = 0; k < 3; k++)
            begin
                num += w[k] * x[k];
                den += w[k];
            end
            mean = (den == 0) ? 64'd0 : num / den;
            for (int k = 0; k < 3; k++)
            begin
                d = (mean >= x[k]) ? mean - x[k] : x[k] - mean;
                w[k] = (64'd1 << (16 + 2 * FRAC)) / ((64'd1 << (2 * FRAC)) + s * d * d);
            end
        end
        return mean[RB-1:0];
    endfunction

    // driver: one item per start, predicted at acceptance
    always @(posedge clk)
    begin
        if (start && !busy)
        begin
            expected_means.push_back(reweighted_mean({reading_a, reading_b, reading_c},
                                                     sharpness));
            items_sent++;
        end
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            trio_t t;
            t = pending_items.pop_front();
            start     <= 1'b1;
            reading_a <= t.a;
            reading_b <= t.b;
            reading_c <= t.c;
        end
        else
            start <= 1'b0;
    end

    // monitor
    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen++;
            if (expected_means.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", robust_mean);
            end
            else
            begin
                logic [RB-1:0] want;
                want = expected_means.pop_front();
                if (want !== robust_mean)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("robust_mean mismatch: expected %h got %h", want, robust_mean);
                end
            end
        end
    end

    task automatic drain;
        while (pending_items.size() > 0 || start || expected_means.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic set_sharpness(logic [7:0] s);
        cfg_write <= 1'b1;
        cfg_data  <= s;
        @(posedge clk);
        cfg_write <= 1'b0;
        sharpness = s;
        sharp_settings++;
    endtask

    function automatic logic [RB-1:0] any_reading();
        case ($urandom_range(4))
            0: return 16'(1 + 2 * $urandom_range(32767) - 1);
            1: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic add_random(int n);
        trio_t t;
        logic [RB-1:0] base;
        for (int i = 0; i < n; i++)
        begin
            base = 16'($urandom);
            if ($urandom_range(1))
            begin
                // two readings close, one outlier
                t.a = base;
                t.b = base + 16'($urandom_range(255)) - 16'd128;
                t.c = any_reading();
            end
            else
            begin
                t.a = any_reading();
                t.b = any_reading();
                t.c = any_reading();
            end
            pending_items.push_back(t);
        end
    endtask

    initial
    begin
        int pct[4];
        logic [7:0] settings[4];
        pct = '{0, 57, 0, 18};
        settings = '{8'd0, 8'd255, 8'd1, 8'($urandom)};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, at reset sharpness
        pending_items.push_back('{16'h0000, 16'h0000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{16'h0000, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{16'hFFFF, 16'h0000, 16'h0000});
        pending_items.push_back('{16'h4000, 16'h4001, 16'hC000});
        pending_items.push_back('{16'h0000, 16'h8000, 16'hFFFF});
        pending_items.push_back('{16'hAAAA, 16'h5555, 16'hAAAA});
        pending_items.push_back('{16'h5555, 16'hAAAA, 16'h5555});
        pending_items.push_back('{16'h0001, 16'h0002, 16'h0003});
        drain();

        // sharpness zero: plain mean
        set_sharpness(8'd0);
        pending_items.push_back('{16'h0000, 16'hFFFF, 16'hFFFF});
        pending_items.push_back('{16'h0001, 16'h0000, 16'h0000});
        pending_items.push_back('{16'hFFFF, 16'h0000, 16'h1234});
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_sharpness(settings[ph]);
            idle_pct = pct[ph];
            add_random(120);
            drain();
        end
        set_sharpness(8'd20);
        idle_pct = 57;
        add_random(250);
        drain();
        set_sharpness(8'd128);
        idle_pct = 18;
        add_random(250);
        drain();

        $display("%0d items over %0d sharpness settings, %0d results checked",
                 items_sent, sharp_settings, results_seen);
        if (mismatches == 0 && expected_means.size() == 0)
            $display("robust_mean_of_three_sensors_test: clean");
        else
            $display("robust_mean_of_three_sensors_test: errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("robust_mean_of_three_sensors_test: errors");
        $finish;
    end

endmodule

// ----- robust_mean_of_three_sensors.f -----
rtl/rmt_pkg.sv
rtl/rmt_div_cell.sv
rtl/rmt_pass.sv
rtl/robust_mean_of_three_sensors.sv
tb/robust_mean_of_three_sensors_test.sv
